// ----- sv/fys_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fys_pkg;

    // Default sizing
    localparam int FYS_STORE_DEPTH = 256;
    localparam int FYS_RANDOM_MAX  = 32767;

    // Field widths fixed by the item format
    localparam int COUNT_W  = 9;
    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int RANDOM_W = 15;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    // Microprogram counter and step addresses
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc UP_IDLE      = 4'd0;
    localparam t_upc UP_DECODE    = 4'd1;
    localparam t_upc UP_LOAD      = 4'd2;
    localparam t_upc UP_CHECK     = 4'd3;
    localparam t_upc UP_DIV1      = 4'd4;
    localparam t_upc UP_DIV1_WAIT = 4'd5;
    localparam t_upc UP_DIV2      = 4'd6;
    localparam t_upc UP_DIV2_WAIT = 4'd7;
    localparam t_upc UP_PICK      = 4'd8;
    localparam t_upc UP_FETCH_J   = 4'd9;
    localparam t_upc UP_STORE_J   = 4'd10;
    localparam t_upc UP_STORE_I   = 4'd11;
    localparam t_upc UP_READ      = 4'd12;
    localparam t_upc UP_READ_CAP  = 4'd13;
    localparam t_upc UP_RESP      = 4'd14;

    // Datapath operation of one control word
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_LOAD       = 4'd1,
        OP_DIV1_START = 4'd2,
        OP_DIV2_START = 4'd3,
        OP_PICK       = 4'd4,
        OP_FETCH_J    = 4'd5,
        OP_STORE_J    = 4'd6,
        OP_STORE_I    = 4'd7,
        OP_READ_ISSUE = 4'd8,
        OP_READ_CAP   = 4'd9,
        OP_RESPOND    = 4'd10
    } t_op;

    // Sequencing of one control word
    typedef enum logic [2:0] {
        J_NEXT        = 3'd0,
        J_GOTO        = 3'd1,
        J_WAIT_START  = 3'd2,
        J_DISPATCH    = 3'd3,
        J_IF_DONE     = 3'd4,
        J_IF_DIV_BUSY = 3'd5
    } t_jmp;

    typedef struct packed {
        t_op  op;
        t_jmp jmp;
        t_upc target;
    } t_uword;

    // Control store
    function automatic t_uword fys_urom(input t_upc pc);
        t_uword w;
        unique case (pc)
            UP_IDLE:      w = '{OP_NONE,       J_WAIT_START,  UP_DECODE};
            UP_DECODE:    w = '{OP_NONE,       J_DISPATCH,    UP_IDLE};
            UP_LOAD:      w = '{OP_LOAD,       J_GOTO,        UP_RESP};
            UP_CHECK:     w = '{OP_NONE,       J_IF_DONE,     UP_RESP};
            UP_DIV1:      w = '{OP_DIV1_START, J_NEXT,        UP_IDLE};
            UP_DIV1_WAIT: w = '{OP_NONE,       J_IF_DIV_BUSY, UP_DIV1_WAIT};
            UP_DIV2:      w = '{OP_DIV2_START, J_NEXT,        UP_IDLE};
            UP_DIV2_WAIT: w = '{OP_NONE,       J_IF_DIV_BUSY, UP_DIV2_WAIT};
            UP_PICK:      w = '{OP_PICK,       J_NEXT,        UP_IDLE};
            UP_FETCH_J:   w = '{OP_FETCH_J,    J_NEXT,        UP_IDLE};
            UP_STORE_J:   w = '{OP_STORE_J,    J_NEXT,        UP_IDLE};
            UP_STORE_I:   w = '{OP_STORE_I,    J_GOTO,        UP_RESP};
            UP_READ:      w = '{OP_READ_ISSUE, J_NEXT,        UP_IDLE};
            UP_READ_CAP:  w = '{OP_READ_CAP,   J_NEXT,        UP_IDLE};
            UP_RESP:      w = '{OP_RESPOND,    J_GOTO,        UP_IDLE};
            default:      w = '{OP_NONE,       J_GOTO,        UP_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/fys_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fys_div #(
    parameter int DW = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_quo, n_quo;
    logic [DW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [DW:0]      trial;
    logic             fits;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? DW'(trial - {1'b0, r_div}) : DW'(trial);
        n_quo = {r_quo[DW-2:0], fits};
    end

    // Count the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Hold remainder, quotient and divisor
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ----- sv/fisher_yates_shuffle_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Load item: decode, load, respond. Read item: decode, read, read capture, respond.
// Step item that is already done: decode, check, respond. Swap step: the bit-serial
// divider of width DW, the wider of RANDOM_MAX's bit count and 15, runs twice.
// One item at a time: the next item is taken in the cycle its result is strobed.
// Synchronous active-low reset clears the sequencer, position and count (to 256);
// the element store is not cleared. The receiver cannot stall results.
module fisher_yates_shuffle_top #(
    parameter int STORE_DEPTH = fys_pkg::FYS_STORE_DEPTH,
    parameter int RANDOM_MAX  = fys_pkg::FYS_RANDOM_MAX
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [fys_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [fys_pkg::INDEX_W-1:0]  i_index,
    input  wire logic [fys_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [fys_pkg::RANDOM_W-1:0] i_random_word,
    output logic                              o_result_strobe,
    output logic [fys_pkg::VALUE_W-1:0]       o_read_value,
    output logic                              o_done_res,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [fys_pkg::COUNT_W-1:0]  i_cfg_data
);

    import fys_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int NW = $clog2(STORE_DEPTH + 1);
    localparam int EW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int RW = $clog2(64'(RANDOM_MAX) + 64'd1);
    localparam int DW = (RW > RANDOM_W) ? RW : RANDOM_W;

    // Sequencer
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   accept;

    // Item and configuration
    logic [MODE_W-1:0]   r_mode;
    logic [INDEX_W-1:0]  r_idx;
    logic [VALUE_W-1:0]  r_val;
    logic [RANDOM_W-1:0] r_rand;
    logic [COUNT_W-1:0]  r_count;

    // Datapath
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_j;
    logic [VALUE_W-1:0] r_store [STORE_DEPTH];
    logic [VALUE_W-1:0] r_rd;
    logic [VALUE_W-1:0] r_hold;
    logic [VALUE_W-1:0] r_rv;
    logic [VALUE_W-1:0] r_out_rv;
    logic               r_out_done;
    logic               r_strobe;

    logic [EW-1:0]      cnt_ext;
    logic [EW-1:0]      n_act;
    logic               done;
    logic               idx_ok;
    logic [DW:0]        j_sum;
    logic [DW:0]        j_max;
    logic [AW-1:0]      j_pick;

    logic               div_load;
    logic [DW-1:0]      div_dividend;
    logic [DW-1:0]      div_divisor;
    logic               div_busy;
    logic [DW-1:0]      div_quo;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [VALUE_W-1:0] mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;

    assign uw     = fys_urom(r_upc);
    assign busy   = (r_upc != UP_IDLE);
    assign accept = start && !busy;

    // Clamp the element count to 1..STORE_DEPTH
    always_comb begin
        cnt_ext = EW'(r_count);
        if (cnt_ext == '0) begin
            n_act = EW'(1);
        end else if ({1'b0, cnt_ext} > (EW + 1)'(STORE_DEPTH)) begin
            n_act = EW'(STORE_DEPTH);
        end else begin
            n_act = cnt_ext;
        end
    end

    assign done   = ((EW + 1)'(r_pos) + (EW + 1)'(1)) >= (EW + 1)'(n_act);
    assign idx_ok = (32'(r_idx) < 32'(STORE_DEPTH));

    // Saturate the swap partner at n - 1
    always_comb begin
        j_sum  = (DW + 1)'(r_pos) + {1'b0, div_quo};
        j_max  = (DW + 1)'(n_act - EW'(1));
        j_pick = (j_sum > j_max) ? AW'(j_max) : AW'(j_sum);
    end

    // Step the microprogram
    always_comb begin
        unique case (uw.jmp)
            J_NEXT:        n_upc = r_upc + t_upc'(1);
            J_GOTO:        n_upc = uw.target;
            J_WAIT_START:  n_upc = start ? uw.target : r_upc;
            J_DISPATCH: begin
                unique case (r_mode)
                    MODE_LOAD: n_upc = UP_LOAD;
                    MODE_STEP: n_upc = UP_CHECK;
                    MODE_READ: n_upc = UP_READ;
                    MODE_NONE: n_upc = UP_RESP;
                endcase
            end
            J_IF_DONE:     n_upc = done ? uw.target : r_upc + t_upc'(1);
            J_IF_DIV_BUSY: n_upc = div_busy ? uw.target : r_upc + t_upc'(1);
            default:       n_upc = UP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_idx  <= i_index;
            r_val  <= i_value;
            r_rand <= i_random_word;
        end
    end

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // Feed the divider: first RANDOM_MAX / (n - i), then r / (quotient + 1)
    always_comb begin
        div_load     = 1'b0;
        div_dividend = DW'(RANDOM_MAX);
        div_divisor  = DW'(n_act - EW'(r_pos));
        if (uw.op == OP_DIV1_START) begin
            div_load = 1'b1;
        end else if (uw.op == OP_DIV2_START) begin
            div_load     = 1'b1;
            div_dividend = DW'(r_rand);
            div_divisor  = div_quo + DW'(1);
        end
    end

    fys_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // Select store port addresses and data per operation
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pos;
        mem_wd = r_rd;
        mem_re = 1'b0;
        mem_ra = r_pos;
        unique case (uw.op)
            OP_LOAD: begin
                mem_we = idx_ok;
                mem_wa = AW'(r_idx);
                mem_wd = r_val;
            end
            OP_PICK: begin
                mem_re = 1'b1;
            end
            OP_FETCH_J: begin
                mem_re = 1'b1;
                mem_ra = r_j;
            end
            OP_STORE_J: begin
                mem_we = 1'b1;
                mem_wa = r_j;
                mem_wd = r_hold;
            end
            OP_STORE_I: begin
                mem_we = 1'b1;
            end
            OP_READ_ISSUE: begin
                mem_re = 1'b1;
                mem_ra = AW'(r_idx);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Element store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_store[mem_ra];
        end
    end

    // Hold the swap partner and element i
    always_ff @(posedge i_clk) begin
        if (uw.op == OP_PICK) begin
            r_j <= j_pick;
        end
        if (uw.op == OP_FETCH_J) begin
            r_hold <= r_rd;
        end
    end

    // Advance or clear the shuffle position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (uw.op == OP_LOAD) begin
            r_pos <= '0;
        end else if (uw.op == OP_STORE_I) begin
            r_pos <= r_pos + AW'(1);
        end
    end

    // Build the read value, zero unless a read finds its element
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rv <= '0;
        end else if (uw.op == OP_READ_CAP) begin
            r_rv <= idx_ok ? r_rd : '0;
        end
    end

    // Strobe the result for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (uw.op == OP_RESPOND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.op == OP_RESPOND) begin
            r_out_rv   <= r_rv;
            r_out_done <= done;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_read_value    = r_out_rv;
    assign o_done_res      = r_out_done;

endmodule
`default_nettype wire

// ----- sv/fys_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fys_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_result_strobe
);

    // A result is never strobed twice in a row
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for two cycles");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // The result appears only once the sequencer is back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy)
        else $error("result strobed while busy");

    // No result right after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_strobe)
        else $error("result strobed in the cycle after accept");

    // Busy rises only because an item was started
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

endmodule

bind fisher_yates_shuffle_top fys_checker u_fys_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import fys_pkg::*;

    localparam int DEPTH        = FYS_STORE_DEPTH;
    localparam int DRAW_MAX     = FYS_RANDOM_MAX;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE_PAD   = 4;
    localparam int FINAL_PAD    = 50;
    localparam int MAX_GAP      = 45;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               done;
    } shuffle_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [MODE_W-1:0]   i_mode = MODE_NONE;
    logic [INDEX_W-1:0]  i_index = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic [RANDOM_W-1:0] i_random_word = '0;
    logic                o_result_strobe;
    logic [VALUE_W-1:0]  o_read_value;
    logic                o_done_res;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [COUNT_W-1:0]  i_cfg_data = '0;

    // Shadow copy of the shuffle engine
    logic [VALUE_W-1:0]  model_store [0:DEPTH-1];
    int unsigned         model_position;
    logic [COUNT_W-1:0]  model_count;

    shuffle_result_t     pending_shuffle_results [$];
    shuffle_result_t     oldest_result;
    int                  error_count = 0;
    int                  items_sent = 0;
    int                  sender_idle_pct = 0;
    int                  burst_left = 0;

    fisher_yates_shuffle_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_value         (i_value),
        .i_random_word   (i_random_word),
        .o_result_strobe (o_result_strobe),
        .o_read_value    (o_read_value),
        .o_done_res      (o_done_res),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Clamp the programmed count to the span the store can hold
    function automatic int unsigned effective_count(input logic [COUNT_W-1:0] cnt);
        int unsigned n;
        n = cnt;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    // Apply one item to the shadow store and return the result it gives
    function automatic shuffle_result_t predict_shuffle_item(
        input logic [MODE_W-1:0]   mode,
        input logic [INDEX_W-1:0]  idx,
        input logic [VALUE_W-1:0]  val,
        input logic [RANDOM_W-1:0] word
    );
        shuffle_result_t res;
        int unsigned     n;
        int unsigned     divisor;
        int unsigned     j;
        logic [VALUE_W-1:0] held;
        n = effective_count(model_count);
        res.read_value = '0;
        case (mode)
            MODE_LOAD: begin
                model_store[idx] = val;
                model_position = 0;
            end
            MODE_STEP: begin
                // Leave everything as is once the position reached n - 1
                if (model_position + 1 < n) begin
                    divisor = DRAW_MAX / (n - model_position) + 1;
                    j = model_position + word / divisor;
                    if (j > n - 1) j = n - 1;
                    held = model_store[j];
                    model_store[j] = model_store[model_position];
                    model_store[model_position] = held;
                    model_position = model_position + 1;
                end
            end
            MODE_READ: begin
                res.read_value = model_store[idx];
            end
            default: ;
        endcase
        res.done = (model_position + 1 >= n);
        return res;
    endfunction

    // Check each strobed result, then record accepted items and register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_position = 0;
            model_count = COUNT_RESET;
        end else begin
            if (o_result_strobe) begin
                if (pending_shuffle_results.size() == 0) begin
                    $error("result strobed with no item outstanding");
                    error_count++;
                end else begin
                    oldest_result = pending_shuffle_results.pop_front();
                    if (o_read_value !== oldest_result.read_value) begin
                        $error("read_value: expected %0h, actual %0h",
                               oldest_result.read_value, o_read_value);
                        error_count++;
                    end
                    if (o_done_res !== oldest_result.done) begin
                        $error("done_res: expected %0b, actual %0b",
                               oldest_result.done, o_done_res);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                pending_shuffle_results.push_back(
                    predict_shuffle_item(i_mode, i_index, i_value, i_random_word));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                model_count = i_cfg_data;
            end
        end
    end

    // Present one item, hold it until taken, then maybe pause
    task automatic send_item(
        input logic [MODE_W-1:0]   mode,
        input logic [INDEX_W-1:0]  idx,
        input logic [VALUE_W-1:0]  val,
        input logic [RANDOM_W-1:0] word
    );
        start <= 1'b1;
        i_mode <= mode;
        i_index <= idx;
        i_value <= val;
        i_random_word <= word;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(99) < 4) begin
            burst_left = $urandom_range(10, 40);
        end else if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every outstanding result has come back
    task automatic wait_idle(input int pad);
        int cycles;
        cycles = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            cycles++;
        end while (pending_shuffle_results.size() != 0 && cycles < DRAIN_LIMIT);
        if (pending_shuffle_results.size() != 0) begin
            $error("%0d results never arrived", pending_shuffle_results.size());
            error_count++;
            pending_shuffle_results.delete();
        end
        repeat (pad) @(posedge i_clk);
    endtask

    // Program the element count while the engine is idle
    task automatic write_element_count(input logic [COUNT_W-1:0] cnt);
        wait_idle(SETTLE_PAD);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [RANDOM_W-1:0] pick_draw();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12) return '0;
        if (sel < 24) return RANDOM_W'(DRAW_MAX);
        return RANDOM_W'($urandom_range(0, DRAW_MAX));
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index(input int unsigned n);
        if ($urandom_range(99) < 80) return INDEX_W'($urandom_range(0, n - 1));
        return INDEX_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Write every entry so that no later read or swap touches an unwritten one
    task automatic test_fill_store();
        int k;
        for (k = 0; k < DEPTH; k++) begin
            if (k == 0)
                send_item(MODE_LOAD, INDEX_W'(k), '0, '0);
            else if (k == DEPTH - 1)
                send_item(MODE_LOAD, INDEX_W'(k), '1, '1);
            else
                send_item(MODE_LOAD, INDEX_W'(k), VALUE_W'($urandom()), pick_draw());
        end
        send_item(MODE_READ, '0, VALUE_W'($urandom()), '1);
        send_item(MODE_READ, '1, VALUE_W'($urandom()), '0);
    endtask

    // Zero count acts as one, oversized count as full depth
    task automatic test_count_limits();
        write_element_count('0);
        send_item(MODE_STEP, '0, '0, pick_draw());
        send_item(MODE_NONE, '1, '1, '1);
        send_item(MODE_READ, '1, '0, '0);
        write_element_count('1);
        send_item(MODE_STEP, '0, '0, '0);
        send_item(MODE_STEP, '1, '1, RANDOM_W'(DRAW_MAX));
        send_item(MODE_READ, '0, '0, '0);
        send_item(MODE_READ, INDEX_W'(1), '0, '0);
        send_item(MODE_READ, '1, '0, '0);
    endtask

    // Run a three element shuffle to completion, then step past the end
    task automatic test_small_shuffle();
        int k;
        write_element_count(COUNT_W'(3));
        send_item(MODE_LOAD, INDEX_W'(2), '1, '0);
        send_item(MODE_STEP, '0, '0, RANDOM_W'(DRAW_MAX));
        send_item(MODE_STEP, '0, '0, '0);
        send_item(MODE_STEP, '0, '0, pick_draw());
        for (k = 0; k < 3; k++) send_item(MODE_READ, INDEX_W'(k), '0, '0);
    endtask

    // Lower the count below the position mid-shuffle, then raise it past depth
    task automatic test_count_lowered();
        write_element_count(COUNT_W'(10));
        repeat (4) send_item(MODE_STEP, '0, '0, pick_draw());
        write_element_count(COUNT_W'(2));
        send_item(MODE_STEP, '0, '0, pick_draw());
        send_item(MODE_READ, '0, '0, '0);
        write_element_count(COUNT_W'(DEPTH + 1));
        send_item(MODE_STEP, '0, '0, pick_draw());
        send_item(MODE_READ, INDEX_W'(4), '0, '0);
    endtask

    // Random shuffle rounds: program a count, load, step through, read back
    task automatic test_random_rounds(input int item_budget, input int idle_pct);
        int          stop_at;
        int          sel;
        int unsigned n;
        int          steps;
        logic [COUNT_W-1:0] cnt;
        sender_idle_pct = idle_pct;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 70)
                cnt = COUNT_W'($urandom_range(1, 16));
            else if (sel < 88)
                cnt = COUNT_W'($urandom_range(17, 64));
            else if (sel < 96)
                cnt = ($urandom_range(1) == 0) ? '0 : COUNT_W'($urandom_range(DEPTH + 1, 511));
            else
                cnt = COUNT_W'($urandom_range(DEPTH - 1, DEPTH));
            write_element_count(cnt);
            n = effective_count(cnt);
            repeat ($urandom_range(1, 4))
                send_item(MODE_LOAD, pick_index(n), VALUE_W'($urandom()), pick_draw());
            steps = n - 1 + $urandom_range(0, 2);
            repeat (steps) begin
                sel = $urandom_range(99);
                // Mix in a few items that break up the swap sequence
                if (sel < 3)
                    send_item(MODE_LOAD, pick_index(n), VALUE_W'($urandom()), pick_draw());
                else if (sel < 7)
                    send_item(MODE_READ, pick_index(n), VALUE_W'($urandom()), pick_draw());
                else if (sel < 10)
                    send_item(MODE_NONE, INDEX_W'($urandom()), VALUE_W'($urandom()),
                              pick_draw());
                else
                    send_item(MODE_STEP, INDEX_W'($urandom()), VALUE_W'($urandom()),
                              pick_draw());
            end
            repeat ($urandom_range(1, (n < 8) ? n : 8))
                send_item(MODE_READ, pick_index(n), VALUE_W'($urandom()), pick_draw());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 21;
        test_fill_store();
        test_count_limits();
        test_small_shuffle();
        test_count_lowered();
        test_random_rounds(480, 21);
        test_random_rounds(480, 76);
        test_random_rounds(480, 0);
        wait_idle(FINAL_PAD);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/fys_pkg.sv
sv/fys_div.sv
sv/fisher_yates_shuffle_top.sv
sv/fys_checker.sv
tb/sv/tb.sv
